// ===== hw/rtl/dtp_pkg.sv =====
`default_nettype none

package dtp_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned NumW    = 17;
    localparam int unsigned SecsW   = 32;

    localparam logic [NumW-1:0]  LimitNumber = NumW'(100000);
    localparam logic [SecsW-1:0] SecsHour    = SecsW'(3600);
    localparam logic [SecsW-1:0] SecsMinute  = SecsW'(60);

    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChH     = 8'h68;
    localparam logic [CharW-1:0] ChI     = 8'h69;
    localparam logic [CharW-1:0] ChM     = 8'h6d;
    localparam logic [CharW-1:0] ChN     = 8'h6e;
    localparam logic [CharW-1:0] ChS     = 8'h73;

    // Parser position within the current term.
    typedef enum logic [4:0] {
        PH_TERM   = 5'b00001,
        PH_NUMBER = 5'b00010,
        PH_GAP    = 5'b00100,
        PH_M      = 5'b01000,
        PH_MI     = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/duration_text_parser_top.sv =====
`default_nettype none

// Streaming duration parser. A text such as "1h 30min" arrives one character
// per input word on char_code; a word with end_of_text set closes the text.
// Terms are a decimal number (at most 100000), optional spaces and a unit of
// h, m, min or s; the block keeps a running total of seconds modulo 2^32.
// Character words produce no output. Each end word produces exactly one
// output word carrying valid_res and seconds (seconds is 0 when the text was
// rejected), and the parser then starts over on a fresh text.
// Both channels use valid/stall: a word moves at a clock edge where valid is
// high and stall is low. Input words land in an input register and are
// parsed by one level of logic into the state and the output register, so
// one word is taken every cycle while in_stall is low. An accepted end word
// shows its result once it is in the output register. When the receiver stalls
// while a result is pending, character words still flow; only a second end
// word waits in the input register, and in_stall is raised until the output
// register frees. Reset (rst_n low, asynchronous) empties both registers and
// returns the parser to the start of a text with a zero total.
module duration_text_parser_top
    import dtp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [CharW-1:0] char_code,
    input  wire logic             end_of_text,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  valid_res,
    output logic [SecsW-1:0]      seconds
);

    // Input register.
    logic             s1_valid_reg;
    logic [CharW-1:0] s1_char_reg;
    logic             s1_end_reg;

    // Parser state.
    phase_t          phase_reg, phase_next;
    logic [NumW-1:0] number_reg, number_next;
    logic [SecsW-1:0] total_reg, total_next;
    logic            seen_reg, seen_next;
    logic            failed_reg, failed_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic             res_ok_reg, res_ok_next;
    logic [SecsW-1:0] res_secs_reg, res_secs_next;

    logic s1_adv;
    logic in_accept;

    // An end word can only leave the input register when the output
    // register is empty or being drained in this cycle.
    assign s1_adv    = s1_valid_reg && (!s1_end_reg || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign valid_res = res_ok_reg;
    assign seconds   = res_secs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg <= char_code;
            s1_end_reg  <= end_of_text;
        end
    end

    // Character classification and the term arithmetic.
    logic             is_digit;
    logic             is_space;
    logic [3:0]       digit;
    logic [NumW+2:0]  num_ext;
    logic [NumW+2:0]  num_tenfold;
    logic [SecsW-1:0] num_wide;
    logic [SecsW-1:0] unit_add;
    logic             unit_hit;
    logic             unit_is_m;
    logic             unit_ok;
    logic [CharW-1:0] ch;

    always_comb
    begin
        ch          = s1_char_reg;
        is_digit    = (ch >= ChZero) && (ch <= ChNine);
        is_space    = (ch == ChSpace);
        digit       = 4'(ch - ChZero);
        num_ext     = (NumW+3)'(number_reg);
        num_tenfold = (num_ext << 3) + (num_ext << 1) + (NumW+3)'(digit);
        num_wide    = SecsW'(number_reg);
        unit_is_m   = (ch == ChM);
        unit_hit    = (ch == ChH) || unit_is_m || (ch == ChS);
        if (ch == ChH)
        begin
            unit_add = num_wide * SecsHour;
        end
        else if (unit_is_m)
        begin
            unit_add = num_wide * SecsMinute;
        end
        else
        begin
            unit_add = num_wide;
        end
        unit_ok = (phase_reg == PH_TERM || phase_reg == PH_M) && seen_reg && !failed_reg;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        number_next    = number_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_ok_next    = res_ok_reg;
        res_secs_next  = res_secs_reg;

        if (s1_adv && s1_end_reg)
        begin
            out_valid_next = 1'b1;
            res_ok_next    = unit_ok;
            res_secs_next  = unit_ok ? total_reg : '0;
            phase_next     = PH_TERM;
            number_next    = '0;
            total_next     = '0;
            seen_next      = 1'b0;
            failed_next    = 1'b0;
        end
        else if (s1_adv && !failed_reg)
        begin
            case (phase_reg)
                PH_TERM, PH_M:
                begin
                    if (phase_reg == PH_M && ch == ChI)
                    begin
                        phase_next = PH_MI;
                    end
                    else if (is_digit)
                    begin
                        number_next = NumW'(digit);
                        phase_next  = PH_NUMBER;
                    end
                    else if (is_space)
                    begin
                        phase_next = PH_TERM;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_NUMBER, PH_GAP:
                begin
                    if (phase_reg == PH_NUMBER && is_digit)
                    begin
                        if (num_tenfold > (NumW+3)'(LimitNumber))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            number_next = NumW'(num_tenfold);
                        end
                    end
                    else if (is_space)
                    begin
                        phase_next = PH_GAP;
                    end
                    else if (unit_hit)
                    begin
                        total_next  = total_reg + unit_add;
                        phase_next  = unit_is_m ? PH_M : PH_TERM;
                        seen_next   = 1'b1;
                        number_next = '0;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_MI:
                begin
                    if (ch == ChN)
                    begin
                        phase_next = PH_TERM;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TERM;
            number_reg    <= '0;
            total_reg     <= '0;
            seen_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            number_reg    <= number_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg   <= res_ok_next;
        res_secs_reg <= res_secs_next;
    end

    // A rejected text always reports a zero total.
    a_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ok_reg) |-> (res_secs_reg == '0))
        else $error("rejected text reports nonzero seconds");

    // Closing a text returns the parser to a clean start.
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_end_reg) |=> (phase_reg == PH_TERM && total_reg == '0
            && !failed_reg && !seen_reg && number_reg == '0))
        else $error("parser state not cleared after end word");

    // The number being read never exceeds the limit.
    a_number_limit: assert property (@(posedge clk) disable iff (!rst_n)
        number_reg <= LimitNumber)
        else $error("number accumulator above limit");

    // Input backpressure only comes from an end word waiting on a full output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_end_reg && out_valid_reg && out_stall))
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

// ===== tb/duration_text_parser_checker.sv =====
`default_nettype none

// Watches both channels of the duration parser, predicts the result of every
// text from the accepted input words and compares each output word with it.
module duration_text_parser_checker
    import dtp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire logic [CharW-1:0] char_code,
    input  wire logic             end_of_text,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire logic             valid_res,
    input  wire logic [SecsW-1:0] seconds,
    output int                    mismatches,
    output int                    awaited,
    output int                    words_parsed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned Radix = 10;

    typedef struct packed {
        logic             ok;
        logic [SecsW-1:0] secs;
    } duration_t;

    duration_t durations_due[$];

    phase_t           where;
    logic [NumW-1:0]  number;
    logic [SecsW-1:0] total;
    logic             have_term;
    logic             rejected;

    function automatic logic is_digit(logic [CharW-1:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function automatic void restart_text();
        where     = PH_TERM;
        number    = '0;
        total     = '0;
        have_term = 1'b0;
        rejected  = 1'b0;
    endfunction

    function automatic void open_term(logic [CharW-1:0] c);
        if (c == ChSpace)
            return;
        if (is_digit(c))
        begin
            number = NumW'(c - ChZero);
            where  = PH_NUMBER;
        end
        else
            rejected = 1'b1;
    endfunction

    function automatic void close_term(logic [CharW-1:0] c);
        if (c == ChH)
        begin
            total = total + SecsW'(number) * SecsHour;
            where = PH_TERM;
        end
        else if (c == ChM)
        begin
            total = total + SecsW'(number) * SecsMinute;
            where = PH_M;
        end
        else if (c == ChS)
        begin
            total = total + SecsW'(number);
            where = PH_TERM;
        end
        else
        begin
            rejected = 1'b1;
            return;
        end
        have_term = 1'b1;
        number    = '0;
    endfunction

    function automatic void parse_char(logic [CharW-1:0] c);
        logic [31:0] grown;
        case (where)
            PH_TERM:
                open_term(c);
            PH_NUMBER:
                if (is_digit(c))
                begin
                    grown = 32'(number) * Radix + 32'(c - ChZero);
                    if (grown > 32'(LimitNumber))
                        rejected = 1'b1;
                    else
                        number = NumW'(grown);
                end
                else if (c == ChSpace)
                    where = PH_GAP;
                else
                    close_term(c);
            PH_GAP:
                if (c != ChSpace)
                    close_term(c);
            PH_M:
                if (c == ChI)
                    where = PH_MI;
                else
                begin
                    where = PH_TERM;
                    open_term(c);
                end
            PH_MI:
                if (c == ChN)
                    where = PH_TERM;
                else
                    rejected = 1'b1;
            default:
                rejected = 1'b1;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic      ok;
        duration_t oldest;
        duration_t fresh;
        if (!rst_n)
        begin
            restart_text();
            durations_due.delete();
            mismatches   = 0;
            words_parsed = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (end_of_text)
                begin
                    ok = !rejected && have_term && (where == PH_TERM || where == PH_M);
                    fresh.ok      = ok;
                    fresh.secs    = ok ? total : {SecsW{1'b0}};
                    durations_due = {durations_due, fresh};
                    restart_text();
                    words_parsed++;
                end
                else if (!rejected)
                begin
                    parse_char(char_code);
                    words_parsed++;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (durations_due.size() == 0)
                begin
                    $error("unexpected result word: valid_res=%0b seconds=%0d",
                           valid_res, seconds);
                    mismatches++;
                end
                else
                begin
                    oldest = durations_due.pop_front();
                    if (valid_res !== oldest.ok)
                    begin
                        $error("valid_res: expected %0b, got %0b", oldest.ok, valid_res);
                        mismatches++;
                    end
                    if (seconds !== oldest.secs)
                    begin
                        $error("seconds: expected %0d, got %0d", oldest.secs, seconds);
                        mismatches++;
                    end
                end
            end
        end
        awaited = durations_due.size();
    end

endmodule

`default_nettype wire

// ===== tb/duration_text_parser_top_test.sv =====
`default_nettype none

// Test of the streaming duration parser. Texts are sent one character per
// word, each closed by an end word; a separate watcher predicts every result
// and compares it with what the block returns. This module only builds the
// stimulus and gives the verdict.
module duration_text_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtp_pkg::*;

    // Each random phase runs for about this many words that the parser
    // actually looks at (characters after an error do not count).
    localparam int PhaseWords = 175;

    // Idle rates for the sender and the receiver, one pair per phase: first
    // a stretch with no idling, then each side alone, then both together.
    int gap_pct_of[4]   = '{0, 77, 0, 28};
    int stall_pct_of[4] = '{0, 0, 77, 28};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid = 1'b0;
    logic [CharW-1:0] char_code = '0;
    logic             end_of_text = 1'b0;
    logic             out_stall = 1'b0;
    wire logic             in_stall;
    wire logic             out_valid;
    wire logic             valid_res;
    wire logic [SecsW-1:0] seconds;

    int mismatches;
    int awaited;
    int words_parsed;

    int send_gap_pct;
    int recv_stall_pct;

    // Characters of the text that is about to be sent.
    logic [CharW-1:0] text_q[$];

    always #1 clk = ~clk;

    duration_text_parser_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .valid_res   (valid_res),
        .seconds     (seconds)
    );

    duration_text_parser_checker duration_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .valid_res    (valid_res),
        .seconds      (seconds),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .words_parsed (words_parsed)
    );

    // The receiver decides afresh at every edge whether to hold off results.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Adds one character at the end of the text.
    function automatic void append_char(logic [CharW-1:0] c);
        text_q = {text_q, c};
    endfunction

    // Offers one word and returns at the edge where it was taken. Idle cycles
    // go in front of the word; valid is only ever assigned once per edge, so
    // back-to-back words keep it high without a glitch.
    task automatic send_word(logic [CharW-1:0] c, logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_text <= last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sends the queued characters and closes the text with an end word, whose
    // character field carries random junk since the block must ignore it.
    task automatic send_text();
        foreach (text_q[i])
            send_word(text_q[i], 1'b0);
        send_word(CharW'($urandom_range(255)), 1'b1);
    endtask

    function automatic void load(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endfunction

    function automatic void put_spaces(int unsigned n);
        repeat (n)
            append_char(ChSpace);
    endfunction

    function automatic void put_number(int unsigned value, int unsigned zeros);
        string digits;
        digits = $sformatf("%0d", value);
        repeat (zeros)
            append_char(ChZero);
        for (int i = 0; i < digits.len(); i++)
            append_char(digits[i]);
    endfunction

    function automatic void put_unit();
        case ($urandom_range(3))
            0: append_char(ChH);
            1: append_char(ChM);
            2:
            begin
                append_char(ChM);
                append_char(ChI);
                append_char(ChN);
            end
            default: append_char(ChS);
        endcase
    endfunction

    // A well-formed text of one to four terms. Most numbers are small; some
    // span the whole legal range, and a few carry leading zeros. Spacing
    // before, inside and between terms varies, including none at all.
    function automatic void build_good_text();
        int unsigned value;
        text_q.delete();
        put_spaces($urandom_range(99) < 70 ? 0 : $urandom_range(1, 2));
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(9))
                0: value = $urandom_range(99990, 100000);
                1, 2: value = $urandom_range(100000);
                default: value = $urandom_range(99);
            endcase
            put_number(value, $urandom_range(9) == 0 ? $urandom_range(1, 3) : 0);
            put_spaces($urandom_range(99) < 75 ? 0 : $urandom_range(1, 2));
            put_unit();
            put_spaces($urandom_range(2));
        end
    endfunction

    // Enough hours near the number limit to push the total past 2^32, so the
    // wrap of the running sum gets exercised.
    function automatic void build_wrapping_text();
        text_q.delete();
        repeat ($urandom_range(13, 14))
        begin
            put_number($urandom_range(99000, 100000), 0);
            append_char(ChH);
        end
    endfunction

    // Starts from a good text and damages it in one of several ways, each
    // aimed at a particular way of rejecting a text.
    function automatic void build_broken_text();
        int idx;
        build_good_text();
        case ($urandom_range(5))
            0:
            begin
                idx = $urandom_range(text_q.size() - 1);
                text_q[idx] = CharW'($urandom_range(255));
            end
            1:
            begin
                idx = $urandom_range(text_q.size());
                text_q.insert(idx, CharW'($urandom_range(255)));
            end
            2:
            begin
                put_number($urandom_range(100001, 999999), 0);
                append_char(ChS);
            end
            3:
                void'(text_q.pop_back());
            4:
            begin
                put_number($urandom_range(59), 0);
                append_char(ChM);
                append_char(ChI);
                append_char(CharW'($urandom_range(255)));
            end
            default:
            begin
                text_q.delete();
                put_spaces($urandom_range(3));
            end
        endcase
    endfunction

    // Short runs of characters, half of them from the ones that matter to the
    // parser and half from the whole byte range.
    function automatic void build_noise_text();
        string useful;
        useful = " 0123456789hmins";
        text_q.delete();
        repeat ($urandom_range(1, 6))
            if ($urandom_range(1))
                append_char(CharW'($urandom_range(255)));
            else
                append_char(useful[$urandom_range(useful.len() - 1)]);
    endfunction

    initial
    begin
        int unsigned start_words;
        int unsigned pick;

        rst_n <= 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts, sent without any idling.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        load("");           // Empty text is not a duration.
        send_text();
        load(" ");          // Nor is a text of spaces only.
        send_text();
        load("1m5s");       // A bare m is a whole unit; the 5 starts a new term.
        send_text();
        load("2min");
        send_text();
        load("1mix");       // The i after m must be followed by n, so x rejects the text.
        send_text();
        load("100001");     // Number over the limit.
        send_text();
        text_q = '{8'hff};  // Top of the byte range where a term should start.
        send_text();
        load("5");          // Code zero where a unit should be.
        append_char(8'h00);
        send_text();

        // Random texts: mostly well formed, the rest broken or plain noise.
        for (int p = 0; p < 4; p++)
        begin
            send_gap_pct   = gap_pct_of[p];
            recv_stall_pct = stall_pct_of[p];
            start_words    = words_parsed;
            while (words_parsed - start_words < PhaseWords)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    build_good_text();
                else if (pick < 63)
                    build_wrapping_text();
                else if (pick < 88)
                    build_broken_text();
                else
                    build_noise_text();
                send_text();
            end
        end
        in_valid <= 1'b0;

        // Let every outstanding result drain, then keep watching in case something
        // stray is still coming out.
        do
            @(negedge clk);
        while (awaited != 0);
        repeat (20)
            @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Guard against a hang: far beyond the length of any correct run.
    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
